// ===== rtl/core/msc_pkg.sv =====
// shared types and constants of the mips subset core
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

  localparam int unsigned DMEM_BYTES = 65536;

  typedef enum logic [1:0] {
    ACT_EXEC     = 2'd0,
    ACT_PRELOAD  = 2'd1,
    ACT_READ_MEM = 2'd2,
    ACT_READ_REG = 2'd3
  } action_e;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_J     = 6'h02;

  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MOP_LOAD,
    MOP_STORE,
    MOP_PRELOAD,
    MOP_DUMP
  } mop_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REG_RD,
    ST_AGEN,
    ST_MEM,
    ST_TAIL,
    ST_LOAD_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/msc_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module msc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/msc_regfile.sv =====
// 32x32 register file, two read ports, r0 and unwritten entries read zero
`timescale 1ns / 1ps
`default_nettype none

module msc_regfile (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [4:0]      raddr_a_i,
  input  logic [4:0]      raddr_b_i,
  input  msc_pkg::rf_wr_t wr_i,
  output logic [31:0]     rdata_a_o,
  output logic [31:0]     rdata_b_o
);
  import msc_pkg::*;

  logic [31:0] valid_q, valid_d;
  logic        ok_a_q, ok_b_q;
  logic [31:0] ram_a, ram_b;
  logic        wr_en;

  // r0 is never stored
  assign wr_en = wr_i.en && (wr_i.addr != 5'd0);

  msc_ram #(.Width(32), .Depth(32)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .raddr_i (raddr_a_i),
    .rdata_o (ram_a)
  );

  msc_ram #(.Width(32), .Depth(32)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .raddr_i (raddr_b_i),
    .rdata_o (ram_b)
  );

  always_comb begin
    valid_d = valid_q;
    if (wr_en) begin
      valid_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ok_a_q  <= 1'b0;
      ok_b_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ok_a_q  <= valid_q[raddr_a_i] && (raddr_a_i != 5'd0);
      ok_b_q  <= valid_q[raddr_b_i] && (raddr_b_i != 5'd0);
    end
  end

  assign rdata_a_o = ok_a_q ? ram_a : '0;
  assign rdata_b_o = ok_b_q ? ram_b : '0;

endmodule

`default_nettype wire

// ===== rtl/core/msc_dm_index.sv =====
// three-stage reduction of a 32-bit byte address modulo the data memory size
`timescale 1ns / 1ps
`default_nettype none

module msc_dm_index #(
  parameter int unsigned DmemBytes = msc_pkg::DMEM_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  addr_i,
  output logic                         done_o,
  output logic [$clog2(DmemBytes)-1:0] idx_o
);
  import msc_pkg::*;

  localparam int unsigned IdxW = $clog2(DmemBytes);
  // byte weights 256^k reduced by the memory size
  localparam logic [15:0] Fold1 = 16'(64'd256 % 64'(DmemBytes));
  localparam logic [15:0] Fold2 = 16'(64'd65536 % 64'(DmemBytes));
  localparam logic [15:0] Fold3 = 16'(64'd16777216 % 64'(DmemBytes));
  // rounded-up reciprocal, scaled by 2^40
  localparam longint unsigned RecipL =
    ((64'd1 << 40) + 64'(DmemBytes) - 64'd1) / 64'(DmemBytes);
  localparam logic [30:0] Recip   = 31'(RecipL);
  localparam logic [16:0] Modulus = 17'(DmemBytes);

  logic        v1_q, v2_q, v3_q;
  logic [25:0] s1_d, s1_q, s2_q;
  logic [16:0] q2_q;
  logic [56:0] prod;
  logic [33:0] back;
  logic [27:0] diff, rem;
  logic [23:0] p1, p2, p3;

  // folded sum is below 2^26
  assign p1   = 24'(addr_i[15:8]) * 24'(Fold1);
  assign p2   = 24'(addr_i[23:16]) * 24'(Fold2);
  assign p3   = 24'(addr_i[31:24]) * 24'(Fold3);
  assign s1_d = 26'(addr_i[7:0]) + 26'(p1) + 26'(p2) + 26'(p3);

  // quotient estimate is exact or one too large
  assign prod = 57'(s1_q) * 57'(Recip);

  assign back = 34'(q2_q) * 34'(Modulus);
  assign diff = 28'(s2_q) - back[27:0];
  assign rem  = diff[27] ? diff + 28'(Modulus) : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s1_q;
    q2_q  <= prod[56:40];
    idx_o <= rem[IdxW-1:0];
  end

  assign done_o = v3_q;

endmodule

`default_nettype wire

// ===== rtl/core/mips_subset_single_cycle_core.sv =====
// mips32 subset core: execute, register read, byte preload and dump requests over valid/stall
// before done: alu, branch, jump, halt exec; register reads reg_rd; preloads agen, mem
// loads exec, agen, mem, tail, load_wb; stores exec, agen, mem; dumps agen, mem, tail
// throughput: one request at a time, the next accepted the cycle after the result registers
// the one-byte data memory port and the three-stage address reduction set memory timing
// reset clears pc, halt flag, register file valid bits and control; data memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_single_cycle_core #(
  parameter int unsigned DmemBytes = msc_pkg::DMEM_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] instr_word_i,
  input  logic [15:0] mem_addr_i,
  input  logic [7:0]  byte_value_i,
  input  logic [4:0]  reg_select_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic        halted_o,
  output logic        illegal_o,
  output logic [31:0] read_value_o
);
  import msc_pkg::*;

  localparam int unsigned IdxW = $clog2(DmemBytes);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DmemBytes - 1);

  // control state
  state_e state_q, state_d;
  mop_e   mop_q, mop_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;
  logic        out_valid_q, out_valid_d;

  // request payload and working registers
  logic [31:0]     instr_q, instr_d;
  logic [7:0]      byte_q, byte_d;
  logic [31:0]     wdata_q, wdata_d;
  logic [31:0]     word_q, word_d;
  logic [31:0]     addr_q, addr_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_nxt;
  logic            ill_q, ill_d;
  logic [31:0]     rv_q, rv_d;

  // result register
  logic [31:0] res_pc_q, res_rv_q;
  logic        res_halt_q, res_ill_q;

  // register file
  logic [4:0]  rf_raddr_a, rf_raddr_b;
  logic [31:0] rf_a, rf_b;
  rf_wr_t      rf_wr;

  // data memory and address reduction
  logic            dm_we;
  logic [7:0]      dm_wdata, dm_rdata;
  logic            idx_start, idx_done;
  logic [31:0]     idx_addr;
  logic [IdxW-1:0] idx_res;

  // decode of the instruction under execution
  action_e     in_act;
  logic        accept, out_free;
  logic [5:0]  op;
  logic [2:0]  fn;
  logic [31:0] imm, pc4, ea, alu;
  logic        alu_ok, is_halt, exec_mem;
  logic        mem_read, last_byte;
  logic [31:0] word_full;

  assign in_act   = action_e'(action_i);
  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign op       = instr_q[31:26];
  assign fn       = instr_q[2:0];
  assign imm      = {{16{instr_q[15]}}, instr_q[15:0]};
  assign pc4      = pc_q + 32'd4;
  assign ea       = rf_a + imm;
  assign is_halt  = (instr_q == HALT_WORD);
  assign exec_mem = !is_halt && ((op == OP_LW) || (op == OP_SW));

  assign mem_read  = (mop_q == MOP_LOAD) || (mop_q == MOP_DUMP);
  assign last_byte = (mop_q == MOP_PRELOAD) || (cnt_q == 2'd3);
  assign word_full = {word_q[23:0], dm_rdata};

  // r-type alu, selected by the low funct bits
  always_comb begin
    alu    = '0;
    alu_ok = 1'b1;
    unique case (fn)
      FN_ADDU: alu = rf_a + rf_b;
      FN_SUBU: alu = rf_a - rf_b;
      FN_AND:  alu = rf_a & rf_b;
      FN_OR:   alu = rf_a | rf_b;
      FN_NOR:  alu = ~(rf_a | rf_b);
      default: alu_ok = 1'b0;
    endcase
  end

  // next byte index: follows the 32-bit address so a wrap past 2^32 lands on entry zero
  assign idx_nxt = (addr_q == 32'hFFFF_FFFF) ? '0 :
                   (idx_q == IdxLast)        ? '0 : idx_q + 1'b1;

  // register file reads are issued in the accept cycle, data is there in the next
  assign rf_raddr_a = (in_act == ACT_READ_REG) ? reg_select_i : instr_word_i[25:21];
  assign rf_raddr_b = instr_word_i[20:16];

  msc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .raddr_a_i (rf_raddr_a),
    .raddr_b_i (rf_raddr_b),
    .wr_i      (rf_wr),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  // preload and dump addresses come straight from the request, loads and stores from the alu
  assign idx_addr = (state_q == ST_IDLE) ? {16'd0, mem_addr_i} : ea;

  msc_dm_index #(.DmemBytes(DmemBytes)) u_dm_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (idx_start),
    .addr_i  (idx_addr),
    .done_o  (idx_done),
    .idx_o   (idx_res)
  );

  // byte-wide data memory, one byte moved per cycle
  msc_ram #(.Width(8), .Depth(DmemBytes)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (idx_q),
    .wdata_i (dm_wdata),
    .raddr_i (idx_q),
    .rdata_o (dm_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_act)
            ACT_EXEC:     state_d = halt_q ? ST_DONE : ST_EXEC;
            ACT_PRELOAD:  state_d = ST_AGEN;
            ACT_READ_MEM: state_d = ST_AGEN;
            ACT_READ_REG: state_d = ST_REG_RD;
          endcase
        end
      end
      ST_EXEC:    state_d = exec_mem ? ST_AGEN : ST_DONE;
      ST_REG_RD:  state_d = ST_DONE;
      ST_AGEN: begin
        if (idx_done) begin
          state_d = ST_MEM;
        end
      end
      ST_MEM: begin
        if (last_byte) begin
          state_d = mem_read ? ST_TAIL : ST_DONE;
        end
      end
      ST_TAIL:    state_d = (mop_q == MOP_LOAD) ? ST_LOAD_WB : ST_DONE;
      ST_LOAD_WB: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // datapath and control outputs
  always_comb begin
    mop_d     = mop_q;
    cnt_d     = cnt_q;
    pc_d      = pc_q;
    halt_d    = halt_q;
    instr_d   = instr_q;
    byte_d    = byte_q;
    wdata_d   = wdata_q;
    word_d    = word_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    ill_d     = ill_q;
    rv_d      = rv_q;
    rf_wr     = '0;
    dm_we     = 1'b0;
    dm_wdata  = wdata_q[31:24];
    idx_start = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          instr_d = instr_word_i;
          byte_d  = byte_value_i;
          addr_d  = {16'd0, mem_addr_i};
          cnt_d   = '0;
          ill_d   = 1'b0;
          rv_d    = '0;
          if (in_act == ACT_PRELOAD) begin
            mop_d     = MOP_PRELOAD;
            idx_start = 1'b1;
          end else if (in_act == ACT_READ_MEM) begin
            mop_d     = MOP_DUMP;
            idx_start = 1'b1;
          end
        end
      end
      ST_EXEC: begin
        if (is_halt) begin
          // halt word keeps the pc
          halt_d = 1'b1;
        end else begin
          pc_d = pc4;
          unique case (op)
            OP_RTYPE: begin
              if (alu_ok) begin
                rf_wr = '{en: 1'b1, addr: instr_q[15:11], data: alu};
              end else begin
                ill_d = 1'b1;
              end
            end
            OP_LW: begin
              mop_d     = MOP_LOAD;
              addr_d    = ea;
              idx_start = 1'b1;
            end
            OP_SW: begin
              mop_d     = MOP_STORE;
              addr_d    = ea;
              wdata_d   = rf_b;
              idx_start = 1'b1;
            end
            OP_ADDIU: rf_wr = '{en: 1'b1, addr: instr_q[20:16], data: ea};
            OP_BEQ: begin
              if (rf_a == rf_b) begin
                pc_d = pc4 + {imm[29:0], 2'b00};
              end
            end
            OP_J:    pc_d = {pc4[31:28], instr_q[25:0], 2'b00};
            default: ill_d = 1'b1;
          endcase
        end
      end
      ST_REG_RD: rv_d = rf_a;
      ST_AGEN: begin
        if (idx_done) begin
          idx_d = idx_res;
        end
      end
      ST_MEM: begin
        unique case (mop_q)
          MOP_LOAD, MOP_DUMP: begin
            // byte k-1 arrives while byte k is addressed
            if (cnt_q != 2'd0) begin
              word_d = word_full;
            end
          end
          MOP_STORE: begin
            // big-endian: most significant byte first
            dm_we   = 1'b1;
            wdata_d = {wdata_q[23:0], 8'd0};
          end
          MOP_PRELOAD: begin
            dm_we    = 1'b1;
            dm_wdata = byte_q;
          end
        endcase
        idx_d  = idx_nxt;
        addr_d = addr_q + 32'd1;
        cnt_d  = cnt_q + 2'd1;
      end
      ST_TAIL: begin
        word_d = word_full;
        if (mop_q == MOP_DUMP) begin
          rv_d = word_full;
        end
      end
      ST_LOAD_WB: rf_wr = '{en: 1'b1, addr: instr_q[20:16], data: word_q};
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mop_q       <= MOP_LOAD;
      cnt_q       <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mop_q       <= mop_d;
      cnt_q       <= cnt_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    instr_q <= instr_d;
    byte_q  <= byte_d;
    wdata_q <= wdata_d;
    word_q  <= word_d;
    addr_q  <= addr_d;
    idx_q   <= idx_d;
    ill_q   <= ill_d;
    rv_q    <= rv_d;
    // result register loads when the request completes and the slot is free
    if ((state_q == ST_DONE) && out_free) begin
      res_pc_q   <= pc_q;
      res_halt_q <= halt_q;
      res_ill_q  <= ill_q;
      res_rv_q   <= rv_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign next_pc_o    = res_pc_q;
  assign halted_o     = res_halt_q;
  assign illegal_o    = res_ill_q;
  assign read_value_o = res_rv_q;

  // the halt flag only clears on reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) halt_q |=> halt_q)
    else $error("halt flag cleared");

  // an execute request on a halted core leaves the pc alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_act == ACT_EXEC) && halt_q) |=> ##1 (pc_q == $past(pc_q, 2)))
    else $error("pc moved while halted");

  // reduced byte index always lands inside the data memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_done |-> ({1'b0, idx_res} < (IdxW + 1)'(DmemBytes)))
    else $error("data memory index out of range");

  // a finished request waits while the previous result is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && out_stall_i) |=>
      ((state_q == ST_DONE) && out_valid_q))
    else $error("result overwritten under stall");

endmodule

`default_nettype wire
